@@ sv/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, command codes and the control program of the I2C master
// bit sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Command codes carried in the op field
  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_ACK   = 3'd2,
    OP_NACK  = 3'd3,
    OP_CHECK = 3'd4,
    OP_WRITE = 3'd5,
    OP_READ  = 3'd6,
    OP_UNDEF = 3'd7   // reserved: taken and dropped
  } op_t;

  localparam int unsigned PC_W   = 5;
  localparam int unsigned BIT_W  = 3;
  localparam int unsigned BYTE_W = 8;

  typedef logic [PC_W-1:0] pc_t;

  // Level source for the pin that a step drives
  typedef enum logic [1:0] {
    V_ZERO = 2'd0,
    V_ONE  = 2'd1,
    V_BIT  = 2'd2
  } val_t;

  // One control word of the program
  typedef struct packed {
    logic pin_sda;  // 0 drives SCL, 1 drives SDA
    val_t val;
    logic last;     // final phase of the command
    logic loop;     // bit loop end: jump back two steps until eight bits done
    logic rep_ack;  // report acknowledge on this phase
    logic rep_rd;   // report read byte on this phase
  } uword_t;

  // One pin phase as handed to the output stage
  typedef struct packed {
    logic              scl;
    logic              sda;
    logic [BYTE_W-1:0] read_data;
    logic              ack_seen;
    logic              last;
  } phase_t;

  // Program entry points
  localparam pc_t A_START = 5'd0;
  localparam pc_t A_STOP  = 5'd3;
  localparam pc_t A_ACK   = 5'd6;
  localparam pc_t A_NACK  = 5'd9;
  localparam pc_t A_CHECK = 5'd13;
  localparam pc_t A_WRITE = 5'd17;
  localparam pc_t A_READ  = 5'd21;

  localparam logic PIN_SCL = 1'b0;
  localparam logic PIN_SDA = 1'b1;

  function automatic uword_t mk(input logic pin, input val_t v, input logic lst,
                                input logic lp, input logic ra, input logic rr);
    uword_t w;
    w.pin_sda = pin;
    w.val     = v;
    w.last    = lst;
    w.loop    = lp;
    w.rep_ack = ra;
    w.rep_rd  = rr;
    return w;
  endfunction

  // Control program, one word per step
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      // start
      5'd0:    w = mk(PIN_SDA, V_ONE,  1'b0, 1'b0, 1'b0, 1'b0);
      5'd1:    w = mk(PIN_SCL, V_ONE,  1'b0, 1'b0, 1'b0, 1'b0);
      5'd2:    w = mk(PIN_SDA, V_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
      // stop
      5'd3:    w = mk(PIN_SDA, V_ZERO, 1'b0, 1'b0, 1'b0, 1'b0);
      5'd4:    w = mk(PIN_SCL, V_ONE,  1'b0, 1'b0, 1'b0, 1'b0);
      5'd5:    w = mk(PIN_SDA, V_ONE,  1'b1, 1'b0, 1'b0, 1'b0);
      // ack
      5'd6:    w = mk(PIN_SDA, V_ZERO, 1'b0, 1'b0, 1'b0, 1'b0);
      5'd7:    w = mk(PIN_SCL, V_ONE,  1'b0, 1'b0, 1'b0, 1'b0);
      5'd8:    w = mk(PIN_SCL, V_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
      // nack
      5'd9:    w = mk(PIN_SCL, V_ZERO, 1'b0, 1'b0, 1'b0, 1'b0);
      5'd10:   w = mk(PIN_SDA, V_ONE,  1'b0, 1'b0, 1'b0, 1'b0);
      5'd11:   w = mk(PIN_SCL, V_ONE,  1'b0, 1'b0, 1'b0, 1'b0);
      5'd12:   w = mk(PIN_SCL, V_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
      // check ack
      5'd13:   w = mk(PIN_SCL, V_ZERO, 1'b0, 1'b0, 1'b0, 1'b0);
      5'd14:   w = mk(PIN_SDA, V_ONE,  1'b0, 1'b0, 1'b0, 1'b0);
      5'd15:   w = mk(PIN_SCL, V_ONE,  1'b0, 1'b0, 1'b0, 1'b0);
      5'd16:   w = mk(PIN_SCL, V_ZERO, 1'b1, 1'b0, 1'b1, 1'b0);
      // write byte
      5'd17:   w = mk(PIN_SCL, V_ZERO, 1'b0, 1'b0, 1'b0, 1'b0);
      5'd18:   w = mk(PIN_SDA, V_BIT,  1'b0, 1'b0, 1'b0, 1'b0);
      5'd19:   w = mk(PIN_SCL, V_ONE,  1'b0, 1'b1, 1'b0, 1'b0);
      5'd20:   w = mk(PIN_SCL, V_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
      // read byte
      5'd21:   w = mk(PIN_SCL, V_ZERO, 1'b0, 1'b0, 1'b0, 1'b0);
      5'd22:   w = mk(PIN_SDA, V_ONE,  1'b0, 1'b0, 1'b0, 1'b0);
      5'd23:   w = mk(PIN_SCL, V_ONE,  1'b0, 1'b1, 1'b0, 1'b0);
      5'd24:   w = mk(PIN_SCL, V_ZERO, 1'b1, 1'b0, 1'b0, 1'b1);
      default: w = mk(PIN_SCL, V_ZERO, 1'b1, 1'b0, 1'b0, 1'b0);
    endcase
    return w;
  endfunction

endpackage

@@ sv/i2cm_if.sv @@
// ----------------------------------------------------------------------------
// i2cm_in_if / i2cm_out_if
// Valid/ready channels for commands and pin phases.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] write_data;
  logic [7:0] line_bits;

  modport source (output valid, output op, output write_data, output line_bits,
                  input ready);
  modport sink   (input valid, input op, input write_data, input line_bits,
                  output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda;
  logic [7:0] read_data;
  logic       ack_seen;
  logic       last;

  modport source (output valid, output scl, output sda, output read_data,
                  output ack_seen, output last, input ready);
  modport sink   (input valid, input scl, input sda, input read_data,
                  input ack_seen, input last, output ready);
endinterface

@@ sv/i2cm_seq.sv @@
// ----------------------------------------------------------------------------
// i2cm_seq
// Microcoded step engine: program counter, bit counter and shift register
// that walk the control program and produce one pin phase per step.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [2:0]                        start_op,
  input  logic [i2cm_pkg::BYTE_W-1:0]       start_wd,
  input  logic [i2cm_pkg::BYTE_W-1:0]       start_lb,
  input  logic                              adv,
  output logic                              busy,
  output i2cm_pkg::phase_t                  phase
);

  logic                          busy_r,  busy_nxt;
  i2cm_pkg::pc_t                 pc_r,    pc_nxt;
  logic [i2cm_pkg::BIT_W-1:0]    cnt_r,   cnt_nxt;
  logic [i2cm_pkg::BYTE_W-1:0]   shift_r, shift_nxt;
  logic [i2cm_pkg::BYTE_W-1:0]   lb_r,    lb_nxt;
  logic                          scl_r,   scl_nxt;
  logic                          sda_r,   sda_nxt;
  i2cm_pkg::uword_t              uw;
  logic                          lvl;
  i2cm_pkg::pc_t                 entry;

  // Map the command to its program entry
  always_comb begin
    case (start_op)
      i2cm_pkg::OP_START: entry = i2cm_pkg::A_START;
      i2cm_pkg::OP_STOP:  entry = i2cm_pkg::A_STOP;
      i2cm_pkg::OP_ACK:   entry = i2cm_pkg::A_ACK;
      i2cm_pkg::OP_NACK:  entry = i2cm_pkg::A_NACK;
      i2cm_pkg::OP_CHECK: entry = i2cm_pkg::A_CHECK;
      i2cm_pkg::OP_WRITE: entry = i2cm_pkg::A_WRITE;
      i2cm_pkg::OP_READ:  entry = i2cm_pkg::A_READ;
      default:            entry = i2cm_pkg::A_START;
    endcase
  end

  // Decode the current word and pick the level it drives
  always_comb begin
    uw = i2cm_pkg::ucode(pc_r);
    case (uw.val)
      i2cm_pkg::V_ZERO: lvl = 1'b0;
      i2cm_pkg::V_ONE:  lvl = 1'b1;
      i2cm_pkg::V_BIT:  lvl = shift_r[i2cm_pkg::BYTE_W-1];
      default:          lvl = 1'b1;
    endcase
  end

  // Step: update a pin, then advance, loop or finish
  always_comb begin
    busy_nxt  = busy_r;
    pc_nxt    = pc_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    lb_nxt    = lb_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    if (start) begin
      busy_nxt  = 1'b1;
      pc_nxt    = entry;
      cnt_nxt   = '0;
      shift_nxt = start_wd;
      lb_nxt    = start_lb;
    end else if (busy_r && adv) begin
      if (uw.pin_sda) begin
        sda_nxt = lvl;
      end else begin
        scl_nxt = lvl;
      end
      if (uw.last) begin
        busy_nxt = 1'b0;
      end else if (uw.loop && (cnt_r != {i2cm_pkg::BIT_W{1'b1}})) begin
        pc_nxt    = pc_r - i2cm_pkg::PC_W'(2);
        cnt_nxt   = cnt_r + i2cm_pkg::BIT_W'(1);
        shift_nxt = {shift_r[i2cm_pkg::BYTE_W-2:0], 1'b0};
      end else begin
        pc_nxt = pc_r + i2cm_pkg::PC_W'(1);
      end
    end
  end

  // Hold control and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
      cnt_r  <= '0;
      scl_r  <= 1'b1;
      sda_r  <= 1'b1;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      cnt_r  <= cnt_nxt;
      scl_r  <= scl_nxt;
      sda_r  <= sda_nxt;
    end
  end

  // Command payload
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    lb_r    <= lb_nxt;
  end

  // Phase as seen after this step
  always_comb begin
    phase.scl       = uw.pin_sda ? scl_r : lvl;
    phase.sda       = uw.pin_sda ? lvl : sda_r;
    phase.read_data = uw.rep_rd ? lb_r : '0;
    phase.ack_seen  = uw.rep_ack & ~lb_r[i2cm_pkg::BYTE_W-1];
    phase.last      = uw.last;
  end

  assign busy = busy_r;

endmodule

@@ sv/i2c_master_bit_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Turns I2C master commands into the sequence of SCL/SDA pin phases.
//
//   channel  dir  payload                                   beats per cmd
//   in_ch    in   op, write_data, line_bits                 1
//   out_ch   out  scl, sda, read_data, ack_seen, last       3, 4 or 25
//
// The step engine yields one phase per cycle unless out_ch stalls, once the
// command has been taken; the input stays closed while a command runs.
// An undefined op is taken and dropped.
// A new command is taken once the previous command's last phase has left the
// engine, even while that phase waits in the output register.
// A stall on out_ch freezes the program counter. Reset (synchronous, low)
// returns both lines to released high and empties the output register.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  i2cm_in_if.sink           in_ch,
  i2cm_out_if.source        out_ch
);

  logic              busy;
  logic              adv;
  logic              start;
  i2cm_pkg::phase_t  phase;
  logic              out_valid_r, out_valid_nxt;
  i2cm_pkg::phase_t  out_phase_r;

  // Take a command whenever the engine is free
  assign in_ch.ready = ~busy;
  assign start       = in_ch.valid & ~busy & (in_ch.op != i2cm_pkg::OP_UNDEF);

  // Advance when the output register is free or drains this cycle
  assign adv = busy & (~out_valid_r | out_ch.ready);

  i2cm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .start_op (in_ch.op),
    .start_wd (in_ch.write_data),
    .start_lb (in_ch.line_bits),
    .adv      (adv),
    .busy     (busy),
    .phase    (phase)
  );

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load a phase beat
  always_ff @(posedge clk) begin
    if (adv) begin
      out_phase_r <= phase;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl       = out_phase_r.scl;
  assign out_ch.sda       = out_phase_r.sda;
  assign out_ch.read_data = out_phase_r.read_data;
  assign out_ch.ack_seen  = out_phase_r.ack_seen;
  assign out_ch.last      = out_phase_r.last;

endmodule

@@ sv/i2cm_checker.sv @@
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the I2C master bit sequencer.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_op,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_last,
  input logic       out_ack_seen,
  input logic [7:0] out_read_data
);

  // A stalled beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out beat dropped while stalled");

  // A byte command keeps the input closed on the next cycle
  a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_op == i2cm_pkg::OP_WRITE || in_op == i2cm_pkg::OP_READ) |=> !in_ready)
    else $error("input open right after byte command");

  // While a non-final phase is shown, the command is still running
  a_mid_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input open in the middle of a command");

  // Reports appear only on a final phase
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ack_seen |-> out_last)
    else $error("ack reported before final phase");

  a_rd_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_data != 8'd0) |-> out_last)
    else $error("read byte reported before final phase");

endmodule

bind i2c_master_bit_sequencer i2cm_checker u_i2cm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_op         (in_ch.op),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_last      (out_ch.last),
  .out_ack_seen  (out_ch.ack_seen),
  .out_read_data (out_ch.read_data)
);
